// File: rtl/core/assert_macros.svh
//==============================================================================
// Assertion macros
// Shared concurrent assertion forms for the checkers of the two-axis PID unit.
//==============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define TAPID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tapid check failed");

// Next-cycle implication, off while reset is asserted.
`define TAPID_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tapid check failed");

`endif

// File: rtl/core/tapid_pkg.sv
//==============================================================================
// tapid_pkg
// Types, constants and microprogram of the two-axis position PID unit.
//==============================================================================
package tapid_pkg;

    localparam int CNT_W       = 16;
    localparam int ANGLE_W     = 32;
    localparam int SUM_W       = 48;
    localparam int GAIN_W      = 24;
    localparam int DUTY_W      = 14;
    localparam int DIR_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int USTEP_W     = 5;
    localparam int MAG_W       = 48;
    localparam int MULA_W      = 26;
    localparam int PROD_W      = MULA_W + GAIN_W;
    localparam int TERM_W      = 61;
    localparam int ACC_W       = 63;
    localparam int DRIVE_W     = 26;

    localparam logic [TERM_W-1:0]  TERM_LIMIT = TERM_W'(1) << 60;
    localparam logic [ACC_W-1:0]   HALF_DRIVE = ACC_W'(1) << 25;
    localparam logic [DUTY_W-1:0]  DUTY_MAX   = 14'd16383;

    typedef logic [USTEP_W-1:0] ustep_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_H = 3'd0,
        REG_TARGET_E = 3'd1,
        REG_GAIN_P_H = 3'd2,
        REG_GAIN_P_E = 3'd3,
        REG_GAIN_I_E = 3'd4,
        REG_GAIN_D_E = 3'd5,
        REG_SCALE_H  = 3'd6,
        REG_SCALE_E  = 3'd7
    } reg_idx_t;

    // operand loaded into the sign/magnitude register
    typedef enum logic [2:0] {
        SRC_NONE, SRC_CNT_H, SRC_CNT_E, SRC_ERR_H, SRC_ERR_E, SRC_SUM, SRC_DIFF, SRC_ACC
    } src_t;

    // multiplier use: low digit, high digit, or drive times full scale
    typedef enum logic [1:0] {
        MUL_NONE, MUL_LO, MUL_HI, MUL_DRV
    } mul_t;

    typedef enum logic [2:0] {
        G_SCALE_H, G_SCALE_E, G_P_H, G_P_E, G_I_E, G_D_E, G_DUTY
    } gsel_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_STEP_H, OP_STEP_E, OP_ANG_H, OP_ANG_E, OP_ERR_H, OP_ERR_E,
        OP_SUM, OP_TERM, OP_LOAD, OP_ACC, OP_PREV
    } op_t;

    typedef enum logic [1:0] {
        WR_NONE, WR_H, WR_E
    } wr_t;

    typedef enum logic [1:0] {
        COND_NONE, COND_NO_INPUT, COND_OUT_BUSY, COND_ALWAYS
    } cond_t;

    typedef struct packed {
        src_t   src;
        mul_t   mul;
        gsel_t  gsel;
        op_t    op;
        wr_t    wr;
        cond_t  cond;
        ustep_t target;
    } uword_t;

    localparam ustep_t STEP_WAIT = 5'd0;
    localparam ustep_t STEP_EMIT = 5'd21;

    function automatic uword_t uw(input src_t src, input mul_t mul, input gsel_t gsel,
                                  input op_t op, input wr_t wr, input cond_t cond,
                                  input ustep_t target);
        uword_t w;
        w.src    = src;
        w.mul    = mul;
        w.gsel   = gsel;
        w.op     = op;
        w.wr     = wr;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // One control tick. A gain multiply spans two words (low then high digit),
    // the term is formed in the next word and summed in the one after;
    // most later operands load while an earlier multiply is still running.
    function automatic uword_t ucode_rom(input ustep_t step);
        uword_t w;
        case (step)
            5'd0:  w = uw(SRC_NONE,  MUL_NONE, G_SCALE_H, OP_NOP,    WR_NONE, COND_NO_INPUT,
                          STEP_WAIT);
            5'd1:  w = uw(SRC_CNT_H, MUL_NONE, G_SCALE_H, OP_NOP,    WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd2:  w = uw(SRC_CNT_E, MUL_LO,   G_SCALE_H, OP_NOP,    WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd3:  w = uw(SRC_NONE,  MUL_LO,   G_SCALE_E, OP_STEP_H, WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd4:  w = uw(SRC_NONE,  MUL_NONE, G_SCALE_H, OP_ANG_H,  WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd5:  w = uw(SRC_NONE,  MUL_NONE, G_SCALE_H, OP_STEP_E, WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd6:  w = uw(SRC_NONE,  MUL_NONE, G_SCALE_H, OP_ERR_H,  WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd7:  w = uw(SRC_ERR_H, MUL_NONE, G_SCALE_H, OP_ANG_E,  WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd8:  w = uw(SRC_NONE,  MUL_LO,   G_P_H,     OP_ERR_E,  WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd9:  w = uw(SRC_ERR_E, MUL_HI,   G_P_H,     OP_SUM,    WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd10: w = uw(SRC_NONE,  MUL_LO,   G_P_E,     OP_TERM,   WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd11: w = uw(SRC_SUM,   MUL_HI,   G_P_E,     OP_LOAD,   WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd12: w = uw(SRC_NONE,  MUL_LO,   G_I_E,     OP_TERM,   WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd13: w = uw(SRC_ACC,   MUL_HI,   G_I_E,     OP_LOAD,   WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd14: w = uw(SRC_DIFF,  MUL_DRV,  G_DUTY,    OP_TERM,   WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd15: w = uw(SRC_NONE,  MUL_LO,   G_D_E,     OP_ACC,    WR_H,    COND_NONE,
                          STEP_WAIT);
            5'd16: w = uw(SRC_NONE,  MUL_HI,   G_D_E,     OP_PREV,   WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd17: w = uw(SRC_NONE,  MUL_NONE, G_SCALE_H, OP_TERM,   WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd18: w = uw(SRC_NONE,  MUL_NONE, G_SCALE_H, OP_ACC,    WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd19: w = uw(SRC_ACC,   MUL_NONE, G_SCALE_H, OP_NOP,    WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd20: w = uw(SRC_NONE,  MUL_DRV,  G_DUTY,    OP_NOP,    WR_NONE, COND_NONE,
                          STEP_WAIT);
            5'd21: w = uw(SRC_NONE,  MUL_NONE, G_SCALE_H, OP_NOP,    WR_E,    COND_OUT_BUSY,
                          STEP_EMIT);
            default: w = uw(SRC_NONE, MUL_NONE, G_SCALE_H, OP_NOP,   WR_NONE, COND_ALWAYS,
                            STEP_WAIT);
        endcase
        return w;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [ANGLE_W:0] x);
        logic signed [ANGLE_W-1:0] r;
        if (x[ANGLE_W] != x[ANGLE_W-1])
            r = x[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
        else
            r = x[ANGLE_W-1:0];
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W:0] x);
        logic signed [SUM_W-1:0] r;
        if (x[SUM_W] != x[SUM_W-1])
            r = x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            r = x[SUM_W-1:0];
        return r;
    endfunction

endpackage

// File: rtl/core/two_axis_position_pid_unit.sv
//==============================================================================
// two_axis_position_pid_unit
// Two-axis position controller: proportional horizontal, PID elevation.
//==============================================================================
// Each input transaction is one control tick carrying the signed encoder
// counts of both axes since the previous tick. The unit scales each count
// to an angle step (Q8.16 scale, rounded), accumulates saturating 32-bit
// angles in 1/1024 degree, forms the error against the programmed targets,
// runs P control on the horizontal axis and PID with a saturating 48-bit
// error sum on the elevation axis, clamps each drive to plus or minus one
// half, and returns one output transaction with a direction code
// (0 stop, 1 forward, 2 reverse) and a PWM duty per axis.
// Sequencing: the 23-word microprogram pushes every product (angle steps,
// four gains split into two 24-bit digits, duty scaling) through one
// shared 26x24 multiplier. The result sits in an output register, so the
// next tick is taken while it still waits; only when a second result is
// ready before the first was taken does the sequencer hold on its emit
// step. Write the configuration registers only while idle.
// Register map (cfg_index): 0 target_horizontal, 1 target_elevation,
// 2 gain_p_horizontal, 3 gain_p_elevation, 4 gain_i_elevation,
// 5 gain_d_elevation, 6 scale_horizontal, 7 scale_elevation; the 24-bit
// registers take cfg_data[23:0].
//==============================================================================
module two_axis_position_pid_unit #(
    parameter int unsigned DUTY_FULL_SCALE = 20000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input tick
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] count_horizontal, [31:16] count_elevation
    input  logic [tapid_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] direction_horizontal, [15:2] duty_horizontal,
    // [17:16] direction_elevation, [31:18] duty_elevation
    output logic [tapid_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tapid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tapid_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tapid_pkg::*;

    localparam logic [GAIN_W-1:0] DUTY_MULT = GAIN_W'(DUTY_FULL_SCALE);

    // sequencer
    ustep_t step_reg;
    ustep_t step_next;
    uword_t uc;
    logic   out_busy;
    logic   in_fire;

    // configuration
    logic signed [ANGLE_W-1:0] tgt_h_reg;
    logic signed [ANGLE_W-1:0] tgt_e_reg;
    logic [GAIN_W-1:0]         gp_h_reg;
    logic [GAIN_W-1:0]         gp_e_reg;
    logic [GAIN_W-1:0]         gi_e_reg;
    logic [GAIN_W-1:0]         gd_e_reg;
    logic [GAIN_W-1:0]         sc_h_reg;
    logic [GAIN_W-1:0]         sc_e_reg;

    // controller state
    logic signed [ANGLE_W-1:0] angle_h_reg;
    logic signed [ANGLE_W-1:0] angle_e_reg;
    logic signed [SUM_W-1:0]   esum_reg;
    logic signed [ANGLE_W-1:0] prev_err_e_reg;

    // datapath registers
    logic signed [CNT_W-1:0]   cnt_h_reg;
    logic signed [CNT_W-1:0]   cnt_e_reg;
    logic signed [24:0]        ang_inc_reg;
    logic signed [ANGLE_W-1:0] err_h_reg;
    logic signed [ANGLE_W-1:0] err_e_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [MAG_W-1:0]          plo_reg;
    logic                      pneg_reg;
    logic                      pzero_reg;
    logic signed [TERM_W:0]    term_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    dir_t                      res_dir_h_reg;
    logic [DUTY_W-1:0]         res_duty_h_reg;
    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic [OUT_TDATA_W-1:0]    m_tdata_reg;

    // combinational datapath
    logic signed [ANGLE_W:0]   diff_e;
    logic signed [MAG_W:0]     src_val;
    logic signed [MAG_W:0]     src_abs;
    logic                      acc_neg;
    logic signed [ACC_W-1:0]   acc_abs;
    logic [DRIVE_W-1:0]        acc_sat;
    logic [MULA_W-1:0]         mul_a;
    logic [GAIN_W-1:0]         mul_b;
    logic [PROD_W-1:0]         mul_p;
    logic                      st_neg;
    logic [40:0]               st_p;
    logic [40:0]               st_x;
    logic signed [ANGLE_W-1:0] ang_cur;
    logic signed [ANGLE_W-1:0] ang_new;
    logic signed [ANGLE_W-1:0] err_new;
    logic signed [SUM_W-1:0]   esum_new;
    logic                      t_big;
    logic [TERM_W-1:0]         t_sum;
    logic [TERM_W-1:0]         t_mag;
    logic signed [TERM_W:0]    t_val;
    dir_t                      drv_dir;
    logic [DUTY_W-1:0]         drv_duty;

    assign uc        = ucode_rom(step_reg);
    assign s_tready  = (step_reg == STEP_WAIT);
    assign in_fire   = s_tvalid && s_tready;
    assign out_busy  = m_tvalid_reg && !m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Step counter: advance, or take the jump when the word's condition holds.
    always_comb
    begin
        case (uc.cond)
            COND_NO_INPUT: step_next = s_tvalid ? ustep_t'(step_reg + 1'b1) : uc.target;
            COND_OUT_BUSY: step_next = out_busy ? uc.target : ustep_t'(step_reg + 1'b1);
            COND_ALWAYS:   step_next = uc.target;
            default:       step_next = ustep_t'(step_reg + 1'b1);
        endcase
    end

    // Operand for the sign/magnitude register.
    assign diff_e = (ANGLE_W+1)'(err_e_reg) - (ANGLE_W+1)'(prev_err_e_reg);

    always_comb
    begin
        case (uc.src)
            SRC_CNT_H: src_val = (MAG_W+1)'(cnt_h_reg);
            SRC_CNT_E: src_val = (MAG_W+1)'(cnt_e_reg);
            SRC_ERR_H: src_val = (MAG_W+1)'(err_h_reg);
            SRC_ERR_E: src_val = (MAG_W+1)'(err_e_reg);
            SRC_SUM:   src_val = (MAG_W+1)'(esum_reg);
            SRC_DIFF:  src_val = (MAG_W+1)'(diff_e);
            default:   src_val = '0;
        endcase
    end

    assign src_abs = src_val[MAG_W] ? -src_val : src_val;

    // Drive magnitude, clamped to one half.
    assign acc_neg = acc_reg[ACC_W-1];
    assign acc_abs = acc_neg ? -acc_reg : acc_reg;
    assign acc_sat = (acc_abs >= signed'(HALF_DRIVE)) ? DRIVE_W'(HALF_DRIVE)
                                                      : acc_abs[DRIVE_W-1:0];

    // Shared multiplier.
    always_comb
    begin
        case (uc.mul)
            MUL_HI:  mul_a = {2'b00, mag_reg[MAG_W-1:24]};
            MUL_DRV: mul_a = mag_reg[MULA_W-1:0];
            default: mul_a = {2'b00, mag_reg[23:0]};
        endcase
        case (uc.gsel)
            G_SCALE_H: mul_b = sc_h_reg;
            G_SCALE_E: mul_b = sc_e_reg;
            G_P_H:     mul_b = gp_h_reg;
            G_P_E:     mul_b = gp_e_reg;
            G_I_E:     mul_b = gi_e_reg;
            G_D_E:     mul_b = gd_e_reg;
            G_DUTY:    mul_b = DUTY_MULT;
            default:   mul_b = '0;
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Angle step: floor((count * scale + 2^15) / 2^16); a negative count
    // negates the product in the same add.
    assign st_neg = (uc.op == OP_STEP_E) ? cnt_e_reg[CNT_W-1] : cnt_h_reg[CNT_W-1];
    assign st_p   = prod_reg[40:0];
    assign st_x   = st_neg ? (~st_p + 41'd32769) : (st_p + 41'd32768);

    assign ang_cur = (uc.op == OP_ANG_E) ? angle_e_reg : angle_h_reg;
    assign ang_new = sat32((ANGLE_W+1)'(ang_cur) + (ANGLE_W+1)'(ang_inc_reg));

    assign err_new = (uc.op == OP_ERR_E)
                   ? sat32((ANGLE_W+1)'(tgt_e_reg) - (ANGLE_W+1)'(angle_e_reg))
                   : sat32((ANGLE_W+1)'(tgt_h_reg) - (ANGLE_W+1)'(angle_h_reg));

    assign esum_new = sat48((SUM_W+1)'(esum_reg) + (SUM_W+1)'(err_e_reg));

    // Gain term from the two digit products, magnitude held at 2^60.
    assign t_big = |prod_reg[PROD_W-1:36];
    assign t_sum = TERM_W'({prod_reg[35:0], 24'b0}) + TERM_W'(plo_reg);
    assign t_mag = (t_big || (t_sum > TERM_LIMIT)) ? TERM_LIMIT : t_sum;
    assign t_val = pneg_reg ? -signed'({1'b0, t_mag}) : signed'({1'b0, t_mag});

    // Direction and duty from the latched drive product.
    assign drv_dir  = pzero_reg ? DIR_STOP : (pneg_reg ? DIR_REV : DIR_FWD);
    assign drv_duty = (|prod_reg[PROD_W-1:40]) ? DUTY_MAX : prod_reg[39:26];

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (uc.wr == WR_E && !out_busy)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    // Control state, configuration and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_WAIT;
            m_tvalid_reg   <= 1'b0;
            tgt_h_reg      <= '0;
            tgt_e_reg      <= '0;
            gp_h_reg       <= 24'd19661;
            gp_e_reg       <= 24'd19661;
            gi_e_reg       <= 24'd1311;
            gd_e_reg       <= 24'd459;
            sc_h_reg       <= 24'd65536;
            sc_e_reg       <= 24'd65536;
            angle_h_reg    <= '0;
            angle_e_reg    <= '0;
            esum_reg       <= '0;
            prev_err_e_reg <= '0;
        end
        else
        begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;

            if (cfg_valid)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_TARGET_H: tgt_h_reg <= signed'(cfg_data);
                    REG_TARGET_E: tgt_e_reg <= signed'(cfg_data);
                    REG_GAIN_P_H: gp_h_reg  <= cfg_data[GAIN_W-1:0];
                    REG_GAIN_P_E: gp_e_reg  <= cfg_data[GAIN_W-1:0];
                    REG_GAIN_I_E: gi_e_reg  <= cfg_data[GAIN_W-1:0];
                    REG_GAIN_D_E: gd_e_reg  <= cfg_data[GAIN_W-1:0];
                    REG_SCALE_H:  sc_h_reg  <= cfg_data[GAIN_W-1:0];
                    REG_SCALE_E:  sc_e_reg  <= cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            case (uc.op)
                OP_ANG_H: angle_h_reg    <= ang_new;
                OP_ANG_E: angle_e_reg    <= ang_new;
                OP_SUM:   esum_reg       <= esum_new;
                OP_PREV:  prev_err_e_reg <= err_e_reg;
                default: ;
            endcase
        end
    end

    // Datapath payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cnt_h_reg <= signed'(s_tdata[CNT_W-1:0]);
            cnt_e_reg <= signed'(s_tdata[2*CNT_W-1:CNT_W]);
        end

        if (uc.src == SRC_ACC)
        begin
            mag_reg <= MAG_W'(acc_sat);
            neg_reg <= acc_neg;
        end
        else if (uc.src != SRC_NONE)
        begin
            mag_reg <= src_abs[MAG_W-1:0];
            neg_reg <= src_val[MAG_W];
        end

        if (uc.mul != MUL_NONE)
            prod_reg <= mul_p;
        // keep the low digit and the sign alongside the high digit
        if (uc.mul == MUL_HI)
            plo_reg <= prod_reg[MAG_W-1:0];
        if (uc.mul == MUL_HI || uc.mul == MUL_DRV)
            pneg_reg <= neg_reg;
        if (uc.mul == MUL_DRV)
            pzero_reg <= (mag_reg == '0);

        case (uc.op)
            OP_STEP_H, OP_STEP_E: ang_inc_reg <= signed'(st_x[40:16]);
            OP_ERR_H:             err_h_reg   <= err_new;
            OP_ERR_E:             err_e_reg   <= err_new;
            OP_TERM:              term_reg    <= t_val;
            OP_LOAD:              acc_reg     <= ACC_W'(term_reg);
            OP_ACC:               acc_reg     <= acc_reg + ACC_W'(term_reg);
            default: ;
        endcase

        if (uc.wr == WR_H)
        begin
            res_dir_h_reg  <= drv_dir;
            res_duty_h_reg <= drv_duty;
        end
        if (uc.wr == WR_E && !out_busy)
            m_tdata_reg <= {drv_duty, drv_dir, res_duty_h_reg, res_dir_h_reg};
    end

endmodule

// File: rtl/core/tapid_chk.sv
//==============================================================================
// tapid_chk
// Port-level checks for the two-axis position PID unit, bound to the top.
//==============================================================================
`include "assert_macros.svh"

module tapid_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [tapid_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import tapid_pkg::*;

    // one tick at a time: no acceptance right after an acceptance
    `TAPID_ASSERT_NXT(a_one_tick, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // a fresh result is loaded only at the end of a tick, never while waiting
    `TAPID_ASSERT_IMP(a_result_end, clk, rst_n, $rose(m_tvalid), !s_tready)
    // stop direction means zero drive, so zero duty
    `TAPID_ASSERT_IMP(a_stop_h, clk, rst_n, m_tvalid && (m_tdata[1:0] == DIR_STOP), m_tdata[15:2] == '0)
    `TAPID_ASSERT_IMP(a_stop_e, clk, rst_n, m_tvalid && (m_tdata[17:16] == DIR_STOP), m_tdata[31:18] == '0)
    // a stalled result holds
    `TAPID_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind two_axis_position_pid_unit tapid_chk u_tapid_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
